>>> rtl/core/tdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// Beat types, mode and status codes shared by the deadline timer queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

  // Request beat
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [47:0] deadline;
    logic [47:0] now_time;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic        fired;
    logic [7:0]  fired_id;
    logic [47:0] fired_deadline;
    logic [1:0]  status;
    logic        last;
    logic        queue_empty;
    logic [47:0] next_deadline;
  } out_beat_t;

  // Flags collected by one pass over the slots
  typedef struct packed {
    logic found;     // a valid slot holds the key id
    logic has_free;  // at least one slot is free
    logic has_min;   // at least one slot is valid
  } scan_res_t;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_EXPIRE  = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  // Most timers fired by one expire request
  localparam int MAX_FIRE      = 16;
  localparam int FIRE_CNT_BITS = $clog2(MAX_FIRE + 1);

endpackage

>>> rtl/core/tdq_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_slots
// Timer slot store: id and deadline memory, plus per-slot valid flops.
// ----------------------------------------------------------------------------
module tdq_slots #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_valid,
  output logic [ID_BITS-1:0]       rd_id,
  output logic [TIME_BITS-1:0]     rd_dl,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [ID_BITS-1:0]       wr_id,
  input  logic [TIME_BITS-1:0]     wr_dl,
  input  logic                     set_en,
  input  logic                     clr_en,
  input  logic [$clog2(DEPTH)-1:0] clr_idx
);

  logic [ID_BITS-1:0]   id_mem [DEPTH];
  logic [TIME_BITS-1:0] dl_mem [DEPTH];
  logic [DEPTH-1:0]     slot_valid;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_idx] <= wr_id;
      dl_mem[wr_idx] <= wr_dl;
    end
    rd_id <= id_mem[rd_addr];
    rd_dl <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (set_en) slot_valid[wr_idx] <= 1'b1;
      if (clr_en) slot_valid[clr_idx] <= 1'b0;
      rd_valid <= slot_valid[rd_addr];
    end
  end

endmodule

>>> rtl/core/tdq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_scan
// Slot scanner: walks every slot once, one per cycle, and keeps the id match,
// the first free slot and the (deadline, id) minimum.
// ----------------------------------------------------------------------------
module tdq_scan #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ID_BITS-1:0]       key_id,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     rd_valid,
  input  logic [ID_BITS-1:0]       rd_id,
  input  logic [TIME_BITS-1:0]     rd_dl,
  output logic                     done,
  output tdq_pkg::scan_res_t       res,
  output logic [$clog2(DEPTH)-1:0] match_idx,
  output logic [$clog2(DEPTH)-1:0] free_idx,
  output logic [$clog2(DEPTH)-1:0] min_idx,
  output logic [ID_BITS-1:0]       min_id,
  output logic [TIME_BITS-1:0]     min_dl
);
  import tdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic          running;
  logic          dv;
  logic [AW-1:0] didx;
  logic          better;

  assign better = !res.has_min || (rd_dl < min_dl) ||
                  ((rd_dl == min_dl) && (rd_id < min_id));

  // Address issue; read data lands in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      dv      <= 1'b0;
      done    <= 1'b0;
      rd_addr <= '0;
      res     <= '0;
    end else begin
      dv   <= running && !start;
      done <= dv && (didx == LAST_IDX);
      if (start) begin
        running <= 1'b1;
        rd_addr <= '0;
        res     <= '0;
      end else begin
        if (running) begin
          if (rd_addr == LAST_IDX) running <= 1'b0;
          else rd_addr <= rd_addr + 1'b1;
        end
        if (dv) begin
          if (rd_valid) begin
            if (!res.found && (rd_id == key_id)) res.found <= 1'b1;
            if (better) res.has_min <= 1'b1;
          end else if (!res.has_free) begin
            res.has_free <= 1'b1;
          end
        end
      end
    end
  end

  // Payload of the accumulators
  always_ff @(posedge clk) begin
    didx <= rd_addr;
    if (dv && !start) begin
      if (rd_valid) begin
        if (!res.found && (rd_id == key_id)) match_idx <= didx;
        if (better) begin
          min_idx <= didx;
          min_id  <= rd_id;
          min_dl  <= rd_dl;
        end
      end else if (!res.has_free) begin
        free_idx <= didx;
      end
    end
  end

endmodule

>>> rtl/core/deadline_timer_queue.sv
`timescale 1ns / 1ps
// Add, remove and restart run two slot scans before the result beat.
// Expire: with none due, one scan; else the first beat follows two scans, and each
// later beat follows one more scan, started once the previous beat is taken.
// Throughput: one request at a time; the next is taken after the last result beat leaves.
// The scan rate is set by the single slot-memory read port, one slot per cycle.
// Reset (rst, synchronous, active high) empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Pending-timer queue ordered by (deadline, id) with add, remove, restart and
// expire requests, built around one shared slot scanner.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdq_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tdq_pkg::out_beat_t  out_data
);
  import tdq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;

  // Latched request
  logic [1:0]           op_mode;
  logic [ID_BITS-1:0]   op_id;
  logic [TIME_BITS-1:0] op_dl;
  logic [TIME_BITS-1:0] op_now;

  // Control registers
  logic                     post, post_next;   // modify done, final scan running
  logic                     pend, pend_next;   // a fired timer is held for output
  logic [1:0]               status, status_next;
  logic [FIRE_CNT_BITS-1:0] nfired;

  // Fired timer held until its beat is built
  logic [ID_BITS-1:0]   fid;
  logic [TIME_BITS-1:0] fdl;

  // Scanner and slot store wiring
  logic                 scan_start, scan_done;
  scan_res_t            sres;
  logic [AW-1:0]        rd_addr, match_idx, free_idx, min_idx;
  logic                 rd_valid;
  logic [ID_BITS-1:0]   rd_id, min_id;
  logic [TIME_BITS-1:0] rd_dl, min_dl;

  logic          wr_en, set_en, clr_en;
  logic [AW-1:0] wr_idx, clr_idx;

  logic emit, emit_fired, emit_last, take_min, due;

  assign in_ready = (state == S_IDLE);
  // Earliest pending timer has come due
  assign due = sres.has_min && (min_dl <= op_now);

  tdq_slots #(
    .DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_id    (rd_id),
    .rd_dl    (rd_dl),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_id    (op_id),
    .wr_dl    (op_dl),
    .set_en   (set_en),
    .clr_en   (clr_en),
    .clr_idx  (clr_idx)
  );

  tdq_scan #(
    .DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .key_id    (op_id),
    .rd_addr   (rd_addr),
    .rd_valid  (rd_valid),
    .rd_id     (rd_id),
    .rd_dl     (rd_dl),
    .done      (scan_done),
    .res       (sres),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .min_idx   (min_idx),
    .min_id    (min_id),
    .min_dl    (min_dl)
  );

  // Sequencer: scan, act on the scan, rescan unless an expire finds none due, emit
  always_comb begin
    state_next  = state;
    post_next   = post;
    pend_next   = pend;
    status_next = status;
    scan_start  = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = free_idx;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_idx     = min_idx;
    take_min    = 1'b0;
    emit        = 1'b0;
    emit_fired  = 1'b0;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next  = S_SCAN;
          scan_start  = 1'b1;
          post_next   = 1'b0;
          pend_next   = 1'b0;
          status_next = ST_OK;
        end
      end
      S_SCAN: begin
        if (scan_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (op_mode == MODE_EXPIRE) begin
          if (pend) begin
            // Report the held timer; queue view comes from the scan after its removal
            emit       = 1'b1;
            emit_fired = 1'b1;
            emit_last  = (nfired == FIRE_CNT_BITS'(MAX_FIRE)) || !due;
          end else if (due) begin
            // Drop the earliest timer and rescan for the new head
            take_min   = 1'b1;
            clr_en     = 1'b1;
            pend_next  = 1'b1;
            scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            emit = 1'b1;
          end
        end else if (!post) begin
          post_next  = 1'b1;
          scan_start = 1'b1;
          state_next = S_SCAN;
          case (op_mode)
            MODE_ADD: begin
              if (sres.found) begin
                status_next = ST_DUP;
              end else if (!sres.has_free) begin
                status_next = ST_FULL;
              end else begin
                wr_en  = 1'b1;
                set_en = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (!sres.found) begin
                status_next = ST_NOT_FOUND;
              end else begin
                clr_en  = 1'b1;
                clr_idx = match_idx;
              end
            end
            default: begin
              // Restart: overwrite the deadline in place
              if (!sres.found) begin
                status_next = ST_NOT_FOUND;
              end else begin
                wr_en  = 1'b1;
                wr_idx = match_idx;
              end
            end
          endcase
        end else begin
          emit = 1'b1;
        end
        if (emit) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (out_data.last) begin
            state_next = S_IDLE;
          end else begin
            // Head is still due: drop it and rescan
            take_min   = 1'b1;
            clr_en     = 1'b1;
            scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      post      <= 1'b0;
      pend      <= 1'b0;
      status    <= ST_OK;
      nfired    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      post   <= post_next;
      pend   <= pend_next;
      status <= status_next;
      if (in_valid && in_ready) nfired <= '0;
      else if (take_min) nfired <= nfired + 1'b1;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload: request fields, held timer, result beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode <= in_data.mode;
      op_id   <= ID_BITS'(in_data.timer_id);
      op_dl   <= TIME_BITS'(in_data.deadline);
      op_now  <= TIME_BITS'(in_data.now_time);
    end
    if (take_min) begin
      fid <= min_id;
      fdl <= min_dl;
    end
    if (emit) begin
      out_data.fired          <= emit_fired;
      out_data.fired_id       <= emit_fired ? 8'(fid) : 8'd0;
      out_data.fired_deadline <= emit_fired ? 48'(fdl) : 48'd0;
      out_data.status         <= status;
      out_data.last           <= emit_last;
      out_data.queue_empty    <= !sres.has_min;
      out_data.next_deadline  <= sres.has_min ? 48'(min_dl) : 48'd0;
    end
  end

endmodule

>>> rtl/core/tdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks for the deadline timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module tdq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tdq_pkg::out_beat_t out_data
);
  import tdq_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // No new request while a result is outstanding
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  // Beats without a fired timer carry zero timer fields
  a_fired_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.fired |->
      out_data.fired_id == 8'd0 && out_data.fired_deadline == 48'd0)
    else $error("non-fired beat carries timer fields");

  // Empty queue reports zero next deadline
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.queue_empty |-> out_data.next_deadline == 48'd0)
    else $error("empty queue with nonzero next deadline");

  // Error status only on a single, final, non-fired beat
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.last && !out_data.fired)
    else $error("error status on a fired or non-final beat");

endmodule

bind deadline_timer_queue tdq_checker u_tdq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
